[sv/gyro_rate_to_speed_and_leds_defines.svh]
// Assertion macros used by the top module.
`ifndef GYRO_RATE_TO_SPEED_AND_LEDS_DEFINES_SVH
`define GYRO_RATE_TO_SPEED_AND_LEDS_DEFINES_SVH

`ifndef SYNTHESIS
`define GRSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GRSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GRSL_ASSERT_IMP(lbl, ante, cons)
`define GRSL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/grsl_pkg.sv]
package grsl_pkg;

  localparam int RateW   = 16;
  localparam int AbsW    = 16;
  localparam int SumW    = 32;
  localparam int SqSteps = AbsW / 2;
  localparam int SqCntW  = $clog2(SqSteps);

  localparam int MagW    = 20;
  localparam int RadW    = 2 * MagW;
  localparam int RemW    = MagW + 1;
  localparam int RtCntW  = $clog2(MagW);

  localparam int SpeedW  = 7;
  localparam int NumW    = MagW + SpeedW;
  localparam int DvCntW  = $clog2(SpeedW);
  localparam logic [SpeedW-1:0] SpeedMax = 7'd100;

  localparam int LedOutW  = 8;
  localparam int LedCount = 8;
  localparam int LedHalf  = LedCount / 2;
  localparam int LedLimit = (LedCount < LedOutW) ? LedCount : LedOutW;
  localparam int BarW     = $clog2(LedCount + 1);
  localparam logic [LedOutW-1:0] LedMask = LedOutW'((32'd1 << LedLimit) - 32'd1);
  localparam int ScaledW  = 12;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;
  localparam int AxThrW   = 16;

  localparam logic [CfgIdxW-1:0] CfgSpeedLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpeedHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAxisLed   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMagLed    = 2'd3;

  localparam logic [MagW-1:0]   RstSpeedLow  = 20'd914;
  localparam logic [MagW-1:0]   RstSpeedHigh = 20'd18286;
  localparam logic [AxThrW-1:0] RstAxisLed   = 16'd228;
  localparam logic [MagW-1:0]   RstMagLed    = 20'd9142;

  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

endpackage

[sv/grsl_sqsum.sv]
module grsl_sqsum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grsl_pkg::AbsW-1:0]  ax_i,
  input  logic [grsl_pkg::AbsW-1:0]  ay_i,
  input  logic [grsl_pkg::AbsW-1:0]  az_i,
  output logic                       done_o,
  output logic [grsl_pkg::SumW-1:0]  sum_o
);

  logic [grsl_pkg::SumW-1:0]   mcand_q [3];
  logic [grsl_pkg::AbsW-1:0]   mplier_q [3];
  logic [grsl_pkg::SumW-1:0]   acc_q [3];
  logic [grsl_pkg::SumW-1:0]   pp [3];
  logic [grsl_pkg::AbsW-1:0]   operand [3];
  logic [grsl_pkg::SqCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        fold_q;
  logic                        done_q;
  logic [grsl_pkg::SumW-1:0]   sum_q;

  assign operand[0] = ax_i;
  assign operand[1] = ay_i;
  assign operand[2] = az_i;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      case (mplier_q[l][1:0])
        2'd0:    pp[l] = '0;
        2'd1:    pp[l] = mcand_q[l];
        2'd2:    pp[l] = mcand_q[l] << 1;
        default: pp[l] = (mcand_q[l] << 1) + mcand_q[l];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fold_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fold_q;
      fold_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == grsl_pkg::SqCntW'(grsl_pkg::SqSteps - 1)) begin
          busy_q <= 1'b0;
          fold_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (start_i) begin
        mcand_q[l]  <= grsl_pkg::SumW'(operand[l]);
        mplier_q[l] <= operand[l];
        acc_q[l]    <= '0;
      end else if (busy_q) begin
        acc_q[l]    <= acc_q[l] + pp[l];
        mcand_q[l]  <= mcand_q[l] << 2;
        mplier_q[l] <= mplier_q[l] >> 2;
      end
    end
    if (fold_q) begin
      sum_q <= acc_q[0] + acc_q[1] + acc_q[2];
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

[sv/grsl_isqrt.sv]
module grsl_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grsl_pkg::SumW-1:0]  sum_i,
  output logic                       done_o,
  output logic [grsl_pkg::MagW-1:0]  root_o
);

  logic [grsl_pkg::RadW-1:0]   rad_q;
  logic [grsl_pkg::RemW-1:0]   rem_q;
  logic [grsl_pkg::MagW-1:0]   root_q;
  logic [grsl_pkg::RtCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [grsl_pkg::RemW+1:0]   rem_sh;
  logic [grsl_pkg::RemW+1:0]   trial;
  logic [grsl_pkg::RemW+1:0]   diff;
  logic                        fits;

  assign rem_sh = {rem_q, rad_q[grsl_pkg::RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == grsl_pkg::RtCntW'(grsl_pkg::MagW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= grsl_pkg::RadW'(sum_i) << (grsl_pkg::RadW - grsl_pkg::SumW);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fits) begin
        rem_q  <= diff[grsl_pkg::RemW-1:0];
        root_q <= {root_q[grsl_pkg::MagW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[grsl_pkg::RemW-1:0];
        root_q <= {root_q[grsl_pkg::MagW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[sv/grsl_div.sv]
module grsl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [grsl_pkg::NumW-1:0]   num_i,
  input  logic [grsl_pkg::MagW-1:0]   den_i,
  output logic                        done_o,
  output logic [grsl_pkg::SpeedW-1:0] quo_o
);

  logic [grsl_pkg::NumW-1:0]   rem_q;
  logic [grsl_pkg::NumW-1:0]   dsh_q;
  logic [grsl_pkg::SpeedW-1:0] quo_q;
  logic [grsl_pkg::DvCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic                        fits;

  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == grsl_pkg::DvCntW'(grsl_pkg::SpeedW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= grsl_pkg::NumW'(den_i) << (grsl_pkg::SpeedW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      dsh_q <= dsh_q >> 1;
      if (fits) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[grsl_pkg::SpeedW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[grsl_pkg::SpeedW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[sv/gyro_rate_to_speed_and_leds.sv]
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       rate_x, rate_y, rate_z
// m_axis    out  m_axis_tvalid_o/tready_i       magnitude_q4, speed_percent, led_pattern
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
// One sample at a time: radix-4 squaring, a fold of the three squares, the bit-serial
// square root, and the restoring divide only when the magnitude is in range, each unit
// handing off to the next, then a load into the output register.
// Reset loads default thresholds and clears the blink phase; no clearing pass.
// A held result waits in the output register; the next request is taken once it loads.
`include "gyro_rate_to_speed_and_leds_defines.svh"

module gyro_rate_to_speed_and_leds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [grsl_pkg::InDataW-1:0]  s_axis_tdata_i,  // rate_x, rate_y, rate_z
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [grsl_pkg::OutDataW-1:0] m_axis_tdata_o,  // magnitude_q4, speed_percent,
                                                         // led_pattern, zero pad
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [grsl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [grsl_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StRt   = 3'd2;
  localparam logic [2:0] StSpd  = 3'd3;
  localparam logic [2:0] StDv   = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [grsl_pkg::MagW-1:0]     low_q, high_q, magthr_q;
  logic [grsl_pkg::AxThrW-1:0]   axthr_q;
  logic                          blink_q;
  logic                          out_valid_q;
  logic [grsl_pkg::OutDataW-1:0] out_data_q;
  logic [grsl_pkg::MagW-1:0]     mag_q;
  logic [grsl_pkg::SpeedW-1:0]   speed_q;
  logic [2:0]                    axflag_q;

  logic                          in_fire;
  logic [grsl_pkg::RateW-1:0]    rx, ry, rz;
  logic [grsl_pkg::AbsW-1:0]     ax, ay, az;
  logic                          sq_done, rt_done, dv_done, dv_start;
  logic [grsl_pkg::SumW-1:0]     sq_sum;
  logic [grsl_pkg::MagW-1:0]     rt_root;
  logic [grsl_pkg::SpeedW-1:0]   dv_quo;
  logic [grsl_pkg::MagW-1:0]     span, offs;
  logic [grsl_pkg::NumW-1:0]     num;
  logic                          below, above, inrange;
  logic                          load;
  logic [grsl_pkg::ScaledW-1:0]  scaled;
  logic [grsl_pkg::BarW-1:0]     bar;
  logic [15:0]                   pat_w;
  logic [grsl_pkg::LedOutW-1:0]  led;
  logic [3:0]                    pairs;

  assign rx = s_axis_tdata_i[15:0];
  assign ry = s_axis_tdata_i[31:16];
  assign rz = s_axis_tdata_i[47:32];
  assign ax = rx[grsl_pkg::RateW-1] ? (~rx + 1'b1) : rx;
  assign ay = ry[grsl_pkg::RateW-1] ? (~ry + 1'b1) : ry;
  assign az = rz[grsl_pkg::RateW-1] ? (~rz + 1'b1) : rz;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  grsl_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .ax_i    (ax),
    .ay_i    (ay),
    .az_i    (az),
    .done_o  (sq_done),
    .sum_o   (sq_sum)
  );

  grsl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_done),
    .sum_i   (sq_sum),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  assign below   = mag_q < low_q;
  assign above   = mag_q > high_q;
  assign inrange = !below && !above && (high_q > low_q);
  assign span    = high_q - low_q;
  assign offs    = mag_q - low_q;
  assign num     = (grsl_pkg::NumW'(offs) << 6) + (grsl_pkg::NumW'(offs) << 5)
                 + (grsl_pkg::NumW'(offs) << 2);
  assign dv_start = (state_q == StSpd) && inrange;

  grsl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (num),
    .den_i   (span),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  assign load = (state_q == StFin) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire) state_d = StSq;
      StSq:    if (sq_done) state_d = StRt;
      StRt:    if (rt_done) state_d = StSpd;
      StSpd:   state_d = inrange ? StDv : StFin;
      StDv:    if (dv_done) state_d = StFin;
      StFin:   if (load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign scaled = grsl_pkg::ScaledW'(speed_q) * grsl_pkg::ScaledW'(grsl_pkg::LedCount);
  assign pairs  = {axflag_q[2], mag_q > magthr_q, axflag_q[1], axflag_q[0]};

  always_comb begin
    bar = '0;
    for (int k = 1; k <= grsl_pkg::LedCount; k++) begin
      if (scaled >= grsl_pkg::ScaledW'(100 * k)) bar = grsl_pkg::BarW'(k);
    end
    pat_w = '0;
    for (int i = 0; i < grsl_pkg::LedCount; i++) begin
      pat_w[i] = (i < bar) && !(grsl_pkg::BarW'(i + 1) == bar && !blink_q);
    end
    for (int k = 0; k < 4; k++) begin
      if (pairs[k]) begin
        pat_w[k] = 1'b1;
        pat_w[k + grsl_pkg::LedHalf] = 1'b1;
      end
    end
    led = pat_w[grsl_pkg::LedOutW-1:0] & grsl_pkg::LedMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      low_q       <= grsl_pkg::RstSpeedLow;
      high_q      <= grsl_pkg::RstSpeedHigh;
      axthr_q     <= grsl_pkg::RstAxisLed;
      magthr_q    <= grsl_pkg::RstMagLed;
      blink_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          grsl_pkg::CfgSpeedLow:  low_q    <= cfg_data_i;
          grsl_pkg::CfgSpeedHigh: high_q   <= cfg_data_i;
          grsl_pkg::CfgAxisLed:   axthr_q  <= cfg_data_i[grsl_pkg::AxThrW-1:0];
          grsl_pkg::CfgMagLed:    magthr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
        blink_q     <= !blink_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axflag_q <= {az > axthr_q, ay > axthr_q, ax > axthr_q};
    end
    if (rt_done) begin
      mag_q <= rt_root;
    end
    if (state_q == StSpd) begin
      speed_q <= (above && !below) ? grsl_pkg::SpeedMax : '0;
    end
    if (dv_done) begin
      speed_q <= dv_quo;
    end
    if (load) begin
      out_data_q <= grsl_pkg::OutDataW'({led, speed_q, mag_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `GRSL_ASSERT_IMP(a_speed_range, state_q == StFin, speed_q <= grsl_pkg::SpeedMax)
  `GRSL_ASSERT_IMP(a_sq_in_step, sq_done, state_q == StSq)
  `GRSL_ASSERT_IMP(a_rt_in_step, rt_done, state_q == StRt)
  `GRSL_ASSERT_NXT(a_blink_toggle, load, blink_q != $past(blink_q))

endmodule

[tb/gyro_rate_to_speed_and_leds_test.sv]
`timescale 1ns / 1ps

module gyro_rate_to_speed_and_leds_test;

  localparam int unsigned TimeoutNs = 10_000_000;
  localparam int unsigned PhaseItems = 320;

  typedef struct {
    int x;
    int y;
    int z;
  } rate_sample_t;

  typedef struct packed {
    logic [grsl_pkg::MagW-1:0]    mag;
    logic [grsl_pkg::SpeedW-1:0]  speed;
    logic [grsl_pkg::LedOutW-1:0] leds;
  } drive_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [grsl_pkg::InDataW-1:0]  s_axis_tdata_i = '0;  // rate_x, rate_y, rate_z
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [grsl_pkg::OutDataW-1:0] m_axis_tdata_o;  // magnitude_q4, speed_percent,
                                                  // led_pattern, zero pad
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [grsl_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [grsl_pkg::CfgDataW-1:0] cfg_data_i = '0;

  gyro_rate_to_speed_and_leds uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  rate_sample_t  pending_samples[$];
  drive_result_t expected_drives[$];
  drive_result_t oldest_drive;

  int unsigned speed_low_thr  = 32'(grsl_pkg::RstSpeedLow);
  int unsigned speed_high_thr = 32'(grsl_pkg::RstSpeedHigh);
  int unsigned axis_thr       = 32'(grsl_pkg::RstAxisLed);
  int unsigned mag_thr        = 32'(grsl_pkg::RstMagLed);
  logic        blink_on       = 1'b0;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        sample_taken   = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic drive_result_t predict_drive(rate_sample_t s);
    drive_result_t r;
    int unsigned ax, ay, az, mag, speed, bar, pattern, limit;
    longint unsigned sq_sum;
    ax = (s.x < 0) ? -s.x : s.x;
    ay = (s.y < 0) ? -s.y : s.y;
    az = (s.z < 0) ? -s.z : s.z;
    sq_sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    mag = 32'(int_sqrt(sq_sum << 8) & 64'hF_FFFF);
    if (mag < speed_low_thr) speed = 0;
    else if (mag > speed_high_thr) speed = 100;
    else if (speed_high_thr > speed_low_thr)
      speed = 32'((longint'(mag - speed_low_thr) * 100) / (speed_high_thr - speed_low_thr));
    else speed = 0;
    bar = speed * grsl_pkg::LedCount / 100;
    pattern = 0;
    if (bar > 0) begin
      pattern = (32'd1 << bar) - 1;
      if (!blink_on) pattern &= ~(32'd1 << (bar - 1));
    end
    blink_on = !blink_on;
    if (ax > axis_thr) pattern |= (32'd1 << 0) | (32'd1 << grsl_pkg::LedHalf);
    if (ay > axis_thr) pattern |= (32'd1 << 1) | (32'd1 << (1 + grsl_pkg::LedHalf));
    if (mag > mag_thr) pattern |= (32'd1 << 2) | (32'd1 << (2 + grsl_pkg::LedHalf));
    if (az > axis_thr) pattern |= (32'd1 << 3) | (32'd1 << (3 + grsl_pkg::LedHalf));
    limit = (grsl_pkg::LedCount < 8) ? grsl_pkg::LedCount : 8;
    pattern &= (32'd1 << limit) - 1;
    r.mag = grsl_pkg::MagW'(mag);
    r.speed = grsl_pkg::SpeedW'(speed);
    r.leds = grsl_pkg::LedOutW'(pattern);
    return r;
  endfunction

  function automatic int signed_axis(int unsigned v, bit neg);
    if (v >= 32768) return -32768;
    return neg ? -int'(v) : int'(v);
  endfunction

  function automatic rate_sample_t random_sample();
    rate_sample_t s;
    int unsigned kind, pick, v;
    kind = $urandom_range(9);
    s.x = 0;
    s.y = 0;
    s.z = 0;
    case (kind)
      0, 1, 2: begin
        s.x = int'($signed(16'($urandom())));
        s.y = int'($signed(16'($urandom())));
        s.z = int'($signed(16'($urandom())));
      end
      3, 4, 5: begin
        s.x = int'($urandom_range(2400)) - 1200;
        s.y = int'($urandom_range(2400)) - 1200;
        s.z = int'($urandom_range(2400)) - 1200;
      end
      6, 7: begin
        v = $urandom_range(2000);
        pick = $urandom_range(2);
        if (pick == 0) s.x = signed_axis(v, $urandom_range(1) != 0);
        else if (pick == 1) s.y = signed_axis(v, $urandom_range(1) != 0);
        else s.z = signed_axis(v, $urandom_range(1) != 0);
      end
      8: begin
        pick = $urandom_range(9);
        case (pick)
          0: v = 0;
          1: v = 1;
          2: v = 100;
          3: v = 32767;
          4: v = 32768;
          5: v = speed_low_thr / 16 + $urandom_range(1);
          6: v = speed_high_thr / 16 + $urandom_range(1);
          7: v = mag_thr / 16 + $urandom_range(1);
          default: v = $urandom_range(32768);
        endcase
        s.x = signed_axis((v > 32768) ? 32768 : v, $urandom_range(1) != 0);
        if ($urandom_range(1) != 0) s.y = int'($signed(16'($urandom())));
      end
      default: begin
        v = axis_thr + $urandom_range(2);
        v = (v == 0) ? 0 : v - 1;
        v = (v > 32768) ? 32768 : v;
        s.x = signed_axis(($urandom_range(1) != 0) ? v : $urandom_range(v),
                          $urandom_range(1) != 0);
        s.y = signed_axis(($urandom_range(1) != 0) ? v : $urandom_range(v),
                          $urandom_range(1) != 0);
        s.z = signed_axis(($urandom_range(1) != 0) ? v : $urandom_range(v),
                          $urandom_range(1) != 0);
      end
    endcase
    return s;
  endfunction

  task automatic queue_sample(int x, int y, int z);
    rate_sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    pending_samples.push_back(s);
    queued_count++;
  endtask

  task automatic write_reg(logic [grsl_pkg::CfgIdxW-1:0] idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= grsl_pkg::CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (accepted_count != queued_count || expected_drives.size() != 0);
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !sample_taken) begin
      // hold the request until taken
    end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i <= {16'(pending_samples[0].z), 16'(pending_samples[0].y),
                         16'(pending_samples[0].x)};
      void'(pending_samples.pop_front());
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      sample_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          grsl_pkg::CfgSpeedLow:  speed_low_thr = 32'(cfg_data_i);
          grsl_pkg::CfgSpeedHigh: speed_high_thr = 32'(cfg_data_i);
          grsl_pkg::CfgAxisLed:   axis_thr = 32'(cfg_data_i[grsl_pkg::AxThrW-1:0]);
          grsl_pkg::CfgMagLed:    mag_thr = 32'(cfg_data_i);
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rate_sample_t s;
        s.x = int'($signed(s_axis_tdata_i[15:0]));
        s.y = int'($signed(s_axis_tdata_i[31:16]));
        s.z = int'($signed(s_axis_tdata_i[47:32]));
        expected_drives.push_back(predict_drive(s));
        accepted_count++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_drives.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", m_axis_tdata_o);
        end else begin
          oldest_drive = expected_drives.pop_front();
          check_field("magnitude_q4", 32'(oldest_drive.mag),
                      32'(m_axis_tdata_o[grsl_pkg::MagW-1:0]));
          check_field("speed_percent", 32'(oldest_drive.speed),
                      32'(m_axis_tdata_o[grsl_pkg::MagW+grsl_pkg::SpeedW-1:grsl_pkg::MagW]));
          check_field("led_pattern", 32'(oldest_drive.leds),
                      32'(m_axis_tdata_o[grsl_pkg::MagW+grsl_pkg::SpeedW+grsl_pkg::LedOutW-1:
                                         grsl_pkg::MagW+grsl_pkg::SpeedW]));
        end
      end
    end
  end

  initial begin
    int unsigned lo, hi, axv, mgv;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 52;
    queue_sample(0, 0, 0);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, -32768, 0);
    queue_sample(228, 0, 0);
    queue_sample(229, 0, 0);
    queue_sample(-229, 0, 0);
    queue_sample(0, 229, 0);
    queue_sample(0, -228, 0);
    queue_sample(0, 0, -229);
    queue_sample(57, 0, 0);
    queue_sample(58, 0, 0);
    queue_sample(571, 0, 0);
    queue_sample(572, 0, 0);
    queue_sample(700, 0, 0);
    queue_sample(700, 0, 0);
    queue_sample(1000, 0, 0);
    queue_sample(1000, 0, 0);
    queue_sample(1142, 0, 0);
    queue_sample(1143, 0, 0);
    queue_sample(0, 2000, 0);
    queue_sample(0, 2000, 0);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 0, 32767);
    queue_sample(1, -1, 1);
    drain();
    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: begin lo = 0;      hi = 908100; axv = 0;     mgv = 0;      end
        2: begin lo = 1600;   hi = 1600;   axv = 32768; mgv = 908100; end
        3: begin lo = 9000;   hi = 3000;   axv = 228;   mgv = 9142;   end
        4: begin lo = 914;    hi = 18286;  axv = 228;   mgv = 9142;   end
        5: begin
          lo = $urandom_range(20000);
          hi = lo + $urandom_range(20000, 1);
          axv = $urandom_range(1500);
          mgv = $urandom_range(30000);
        end
        default: begin lo = 0; hi = 1; axv = 32768; mgv = 908100; end
      endcase
      if (p <= 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 52;
      end else if (p <= 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(grsl_pkg::CfgSpeedLow, lo);
      write_reg(grsl_pkg::CfgSpeedHigh, hi);
      write_reg(grsl_pkg::CfgAxisLed, axv);
      write_reg(grsl_pkg::CfgMagLed, mgv);
      cfg_valid_i <= 1'b0;
      for (int i = 0; i < PhaseItems; i++) begin
        rate_sample_t s;
        s = random_sample();
        queue_sample(s.x, s.y, s.z);
      end
      drain();
    end
    repeat (60) @(negedge clk_i);
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

endmodule
